// ----- rtl/nnvd_pkg.sv -----
// Shared types and constants for the nearest-neighbor volume decimator.
package nnvd_pkg;

    // Largest supported size on any axis
    localparam int MAX_DIM  = 4096;
    // Width of a position or destination index (0 .. MAX_DIM-1)
    localparam int POS_W    = $clog2(MAX_DIM);
    // Width of a size value (1 .. MAX_DIM) and of a size register
    localparam int SIZE_W   = POS_W + 1;
    // Signed error term, range -MAX_DIM .. 3*MAX_DIM-1
    localparam int ACC_W    = POS_W + 3;
    localparam int DATA_W   = 32;
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int IDX_W    = ADDR_W - 2;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SRC_W = IDX_W'(0),
        REG_SRC_H = IDX_W'(1),
        REG_SRC_D = IDX_W'(2),
        REG_DST_W = IDX_W'(3),
        REG_DST_H = IDX_W'(4),
        REG_DST_D = IDX_W'(5)
    } reg_idx_t;

    // Effective sizes on one axis
    typedef struct packed {
        logic [SIZE_W-1:0] src;
        logic [SIZE_W-1:0] dst;
    } axis_size_t;

    // Configuration seen by the datapath
    typedef struct packed {
        axis_size_t x;
        axis_size_t y;
        axis_size_t z;
        logic       restart;
    } cfg_ctrl_t;

    // Limit a size register to 1 .. MAX_DIM
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        begin
            if (v == '0)
                r = SIZE_W'(1);
            else if (v > SIZE_W'(MAX_DIM))
                r = SIZE_W'(MAX_DIM);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// ----- rtl/nearest_neighbor_volume_decimator.sv -----
// Top level of the nearest-neighbor 3D volume decimator.
//
//   Channel  Handshake          Payload
//   in       in_valid/in_stall  voxel_in[31:0]
//   out      out_valid/out_stall voxel_out[31:0], volume_last
//   cfg      APB psel/penable   paddr[4:0], pwdata, prdata (6 size registers)
//
// One source word is taken per cycle while in_stall is low; a selected word
// is registered in the output word, or in the skid word while that is held.
// Each axis selects with one compare. in_stall rises only when both the
// output word and the skid word are held. Reset sets all sizes to 1 and all
// positions to zero; a write to a size register restarts the volume.
module nearest_neighbor_volume_decimator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nnvd_pkg::DATA_W-1:0]   voxel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nnvd_pkg::DATA_W-1:0]   voxel_out,
    output logic                          volume_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnvd_pkg::ADDR_W-1:0]   paddr,
    input  logic [nnvd_pkg::DATA_W-1:0]   pwdata,
    output logic [nnvd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import nnvd_pkg::*;

    cfg_ctrl_t ctrl;
    logic      accept;
    logic      full;
    logic      sel_x, sel_y, sel_z;
    logic      last_x, last_y, last_z;
    logic      wrap_x, wrap_y, wrap_z;
    logic      step_y, step_z;
    logic      push;

    nnvd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctrl    (ctrl)
    );

    // Accept a word whenever the skid stage is empty
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Step axes in raster order
    assign step_y = accept && wrap_x;
    assign step_z = accept && wrap_x && wrap_y;

    nnvd_axis u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctrl.restart),
        .step  (accept),
        .size  (ctrl.x),
        .sel   (sel_x),
        .last  (last_x),
        .wrap  (wrap_x)
    );

    nnvd_axis u_axis_y (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctrl.restart),
        .step  (step_y),
        .size  (ctrl.y),
        .sel   (sel_y),
        .last  (last_y),
        .wrap  (wrap_y)
    );

    nnvd_axis u_axis_z (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (ctrl.restart),
        .step  (step_z),
        .size  (ctrl.z),
        .sel   (sel_z),
        .last  (last_z),
        .wrap  (wrap_z)
    );

    // Pass the word on when all three axes select it
    assign push = accept && sel_x && sel_y && sel_z;

    nnvd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (voxel_in),
        .push_last   (last_x && last_y && last_z),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .voxel_out   (voxel_out),
        .volume_last (volume_last)
    );

endmodule

// ----- rtl/nnvd_cfg.sv -----
// Configuration registers with APB access and effective-size derivation.
module nnvd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnvd_pkg::ADDR_W-1:0]   paddr,
    input  logic [nnvd_pkg::DATA_W-1:0]   pwdata,
    output logic [nnvd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output nnvd_pkg::cfg_ctrl_t           ctrl
);
    import nnvd_pkg::*;

    logic [SIZE_W-1:0] regs_reg [NUM_REGS];
    logic [SIZE_W-1:0] regs_next [NUM_REGS];
    logic              restart_next;
    logic [IDX_W-1:0]  idx;
    logic              wr_en;
    logic [SIZE_W-1:0] src_w, src_h, src_d, dst_w, dst_h, dst_d;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Store a write to a listed register and restart the volume on the same edge
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        restart_next = 1'b0;
        if (wr_en && (idx < IDX_W'(NUM_REGS)))
        begin
            regs_next[idx] = pwdata[SIZE_W-1:0];
            restart_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= SIZE_W'(1);
            end
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
        end
    end

    // Read back the stored register
    always_comb
    begin
        case (idx)
            REG_SRC_W: prdata = DATA_W'(regs_reg[REG_SRC_W]);
            REG_SRC_H: prdata = DATA_W'(regs_reg[REG_SRC_H]);
            REG_SRC_D: prdata = DATA_W'(regs_reg[REG_SRC_D]);
            REG_DST_W: prdata = DATA_W'(regs_reg[REG_DST_W]);
            REG_DST_H: prdata = DATA_W'(regs_reg[REG_DST_H]);
            REG_DST_D: prdata = DATA_W'(regs_reg[REG_DST_D]);
            default:   prdata = '0;
        endcase
    end

    // Clamp sizes, and hold each target at or below its source
    assign src_w = clamp_size(regs_reg[REG_SRC_W]);
    assign src_h = clamp_size(regs_reg[REG_SRC_H]);
    assign src_d = clamp_size(regs_reg[REG_SRC_D]);
    assign dst_w = clamp_size(regs_reg[REG_DST_W]);
    assign dst_h = clamp_size(regs_reg[REG_DST_H]);
    assign dst_d = clamp_size(regs_reg[REG_DST_D]);

    assign ctrl.x.src   = src_w;
    assign ctrl.x.dst   = (dst_w > src_w) ? src_w : dst_w;
    assign ctrl.y.src   = src_h;
    assign ctrl.y.dst   = (dst_h > src_h) ? src_h : dst_h;
    assign ctrl.z.src   = src_d;
    assign ctrl.z.dst   = (dst_d > src_d) ? src_d : dst_d;
    assign ctrl.restart = restart_next;

endmodule

// ----- rtl/nnvd_axis.sv -----
// One axis: source position, selection error term and destination index.
module nnvd_axis (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 step,
    input  nnvd_pkg::axis_size_t size,
    output logic                 sel,
    output logic                 last,
    output logic                 wrap
);
    import nnvd_pkg::*;

    // acc holds 2*k*S + T - 2*T*i - T for source index i and next destination k;
    // index i is selected when acc < T.
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [POS_W-1:0]        k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] t_ext, s_ext;

    assign t_ext = signed'(ACC_W'(size.dst));
    assign s_ext = signed'(ACC_W'(size.src));

    assign sel  = acc_reg < t_ext;
    assign wrap = {1'b0, pos_reg} == (size.src - SIZE_W'(1));
    assign last = sel && ({1'b0, k_reg} == (size.dst - SIZE_W'(1)));

    // Clear on restart, else step one source index and restart at the axis end
    always_comb
    begin
        pos_next = pos_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        if (clear)
        begin
            pos_next = '0;
            k_next   = '0;
            acc_next = '0;
        end
        else if (step)
        begin
            if (wrap)
            begin
                pos_next = '0;
                k_next   = '0;
                acc_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                k_next   = k_reg + POS_W'(sel);
                acc_next = acc_reg - (t_ext <<< 1) + (sel ? (s_ext <<< 1) : '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            k_reg   <= k_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- rtl/nnvd_out.sv -----
// Output register with a skid stage for the selected voxel words.
module nnvd_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [nnvd_pkg::DATA_W-1:0] push_data,
    input  logic                        push_last,
    output logic                        full,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [nnvd_pkg::DATA_W-1:0] voxel_out,
    output logic                        volume_last
);
    import nnvd_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              skid_last_reg, skid_last_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Fill output from skid first, else from push; push goes to skid if held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
                out_last_next  = push_last;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
            skid_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
    end

    assign full        = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign voxel_out   = out_data_reg;
    assign volume_last = out_last_reg;

endmodule
